// ===== rtl/cfr_pkg.sv =====
// Shared types, constants and the CRC-16/Modbus byte step for the frame receiver.
package cfr_pkg;

    localparam logic [3:0]  FRAME_BYTES  = 4'd9;
    localparam logic [3:0]  COUNT_MAX    = 4'd15;
    localparam logic [3:0]  LAST_PAYLOAD = 4'd6;
    localparam logic [3:0]  LAST_CRC     = 4'd8;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_LEN   = 2'd1,
        STATUS_START = 2'd2,
        STATUS_CRC   = 2'd3
    } t_status;

    // One judged frame, passed from the front to the back through the queue
    typedef struct packed {
        t_status     status;
        logic [47:0] payload;
    } t_verdict;

    // Advance the reflected CRC by one byte, eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/cfr_ifs.sv =====
// Valid/ready channel interfaces for the input, result and configuration words.
interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       is_idle;
    modport source(output valid, output rx_byte, output is_idle, input ready);
    modport sink(input valid, input rx_byte, input is_idle, output ready);
endinterface

interface cfr_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic signed [15:0] value_z;
    modport source(output valid, output status, output value_x, output value_y,
                   output value_z, input ready);
    modport sink(input valid, input status, input value_x, input value_y,
                 input value_z, output ready);
endinterface

interface cfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] start_byte;
    modport source(output valid, output start_byte, input ready);
    modport sink(input valid, input start_byte, output ready);
endinterface

// ===== rtl/cfr_front.sv =====
// Front end: frame assembly, running CRC and the verdict on each idle event.
module cfr_front
    import cfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfr_in_if.sink    i_in,
    cfr_cfg_if.sink   i_cfg,
    input  logic      i_full,
    output logic      o_push,
    output t_verdict  o_verdict
);

    logic [7:0]  r_start_byte;
    logic [3:0]  r_byte_count, n_byte_count;
    logic        r_first_ok, n_first_ok;
    logic [15:0] r_crc, n_crc;
    logic [47:0] r_payload, n_payload;
    logic [15:0] r_rx_crc, n_rx_crc;
    logic        acc;
    t_status     verdict;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign acc         = i_in.valid && i_in.ready;

    // Judge the frame: length first, then start byte, then CRC
    always_comb begin
        if (r_byte_count != FRAME_BYTES) begin
            verdict = STATUS_LEN;
        end else if (!r_first_ok) begin
            verdict = STATUS_START;
        end else if (r_crc != r_rx_crc) begin
            verdict = STATUS_CRC;
        end else begin
            verdict = STATUS_OK;
        end
    end

    assign o_push            = acc && i_in.is_idle;
    assign o_verdict.status  = verdict;
    assign o_verdict.payload = r_payload;

    // Advance the frame state on a data word, clear it on an idle word
    always_comb begin
        n_byte_count = r_byte_count;
        n_first_ok   = r_first_ok;
        n_crc        = r_crc;
        n_payload    = r_payload;
        n_rx_crc     = r_rx_crc;
        if (acc) begin
            if (i_in.is_idle) begin
                n_byte_count = '0;
                n_first_ok   = 1'b0;
                n_crc        = CRC_INIT;
                n_payload    = '0;
                n_rx_crc     = '0;
            end else begin
                if (r_byte_count == '0) begin
                    n_first_ok = (i_in.rx_byte == r_start_byte);
                end else if (r_byte_count <= LAST_PAYLOAD) begin
                    n_crc     = crc_byte(r_crc, i_in.rx_byte);
                    n_payload = {r_payload[39:0], i_in.rx_byte};
                end else if (r_byte_count <= LAST_CRC) begin
                    n_rx_crc = {r_rx_crc[7:0], i_in.rx_byte};
                end
                if (r_byte_count != COUNT_MAX) begin
                    n_byte_count = r_byte_count + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
            r_byte_count <= '0;
            r_first_ok   <= 1'b0;
            r_crc        <= CRC_INIT;
            r_payload    <= '0;
            r_rx_crc     <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_start_byte <= i_cfg.start_byte;
            end
            r_byte_count <= n_byte_count;
            r_first_ok   <= n_first_ok;
            r_crc        <= n_crc;
            r_payload    <= n_payload;
            r_rx_crc     <= n_rx_crc;
        end
    end

    // An idle word always leaves an empty frame with a fresh CRC
    a_idle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_byte_count == '0) && (r_crc == CRC_INIT))
        else $error("frame state not cleared after idle word");

endmodule

// ===== rtl/cfr_queue.sv =====
// Short verdict queue between front and back.
module cfr_queue
    import cfr_pkg::*;
#(
    parameter int DEPTH = 2
)(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_verdict i_entry,
    output logic     o_full,
    input  logic     i_pop,
    output t_verdict o_entry,
    output logic     o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_verdict        r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Write the entry at the tail
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("verdict pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("verdict popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

// ===== rtl/cfr_back.sv =====
// Back end: apply accepted verdicts to the held values and present results.
module cfr_back
    import cfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_verdict  i_entry,
    output logic      o_pop,
    cfr_out_if.source o_out
);

    logic        r_valid;
    t_status     r_status;
    logic [15:0] r_held_x, r_held_y, r_held_z;

    // Take a verdict when the output register is free or being drained
    assign o_pop = !i_empty && (!r_valid || o_out.ready);

    assign o_out.valid   = r_valid;
    assign o_out.status  = r_status;
    assign o_out.value_x = r_held_x;
    assign o_out.value_y = r_held_y;
    assign o_out.value_z = r_held_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_status <= STATUS_OK;
            r_held_x <= '0;
            r_held_y <= '0;
            r_held_z <= '0;
        end else begin
            if (o_pop) begin
                r_valid  <= 1'b1;
                r_status <= i_entry.status;
                if (i_entry.status == STATUS_OK) begin
                    r_held_x <= i_entry.payload[47:32];
                    r_held_y <= i_entry.payload[31:16];
                    r_held_z <= i_entry.payload[15:0];
                end
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.status == STATUS_OK) |=>
            (r_held_z == $past(i_entry.payload[15:0])) && (r_status == STATUS_OK))
        else $error("accepted frame did not load held values");

endmodule

// ===== rtl/crc16_checked_frame_receiver_unit.sv =====
// Top level of the CRC-16/Modbus checked frame receiver.
//
//   channel  dir  words carried
//   i_in     in   rx_byte[7:0], is_idle  (data byte or line-idle event)
//   o_out    out  status[1:0], value_x/y/z signed[15:0], one per idle event
//   i_cfg    in   start_byte[7:0], always ready
//
// One input word is taken per cycle while the verdict queue is not full; the byte-wide CRC step sets that figure.
// Each verdict passes through the verdict queue, then the output register.
// i_in.ready drops only while the verdict queue is full (output stalled).
// Synchronous active-low reset clears frame state, held values and start_byte.
module crc16_checked_frame_receiver_unit
    import cfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfr_in_if.sink     i_in,
    cfr_cfg_if.sink    i_cfg,
    cfr_out_if.source  o_out
);

    logic     push, pop, full, empty;
    t_verdict push_entry, pop_entry;

    cfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_full    (full),
        .o_push    (push),
        .o_verdict (push_entry)
    );

    cfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_empty (empty)
    );

    cfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
